/* src/radix_digit_emitter_core_assert.svh */
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared concurrent assertion forms used by the emitter core.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rde: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rde: next-cycle check failed");

`endif

/* src/rde_pkg.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Shared types, constants and the digit glyph table.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_W    = 32;  // width of the input value field
  localparam int CHAR_W     = 7;   // width of an ASCII character
  localparam int DIGIT_W    = 4;   // width of one stored digit
  localparam int BASE_W     = 5;   // width of the base register
  localparam int STEPS      = 8;   // division bits retired per cycle
  localparam int DATA_W     = 32;  // configuration data width
  localparam int PADDR_W    = 3;   // configuration byte address width
  localparam int REG_IDX_W  = 1;   // register index bits above the byte offset

  localparam logic [BASE_W-1:0]    BASE_RESET  = 5'd10;
  localparam logic [BASE_W-1:0]    BASE_MIN    = 5'd2;
  localparam logic [BASE_W-1:0]    BASE_MAX    = 5'd16;
  localparam logic [REG_IDX_W-1:0] REG_IDX_BASE = 1'b0;

  localparam logic [CHAR_W-1:0] GLYPH_TABLE [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_value;
    logic div_step;
    logic pop_read;
    logic out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic chunk_last;
    logic quot_zero;
    logic depth_zero;
    logic store_full;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    return GLYPH_TABLE[d];
  endfunction

endpackage

/* src/rde_stream_if.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter stream interfaces
// Valid/ready channels for the value input and the digit output.
// ----------------------------------------------------------------------------
interface rde_in_if;
  logic                        valid;
  logic                        ready;
  logic [rde_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rde_out_if;
  logic                       valid;
  logic                       ready;
  logic [rde_pkg::CHAR_W-1:0] digit_char;
  logic                       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* src/rde_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter configuration registers
// APB-style register port holding the base register and its clamped value.
// ----------------------------------------------------------------------------
module rde_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rde_pkg::PADDR_W-1:0]  paddr,
  input  logic [rde_pkg::DATA_W-1:0]   pwdata,
  output logic [rde_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [rde_pkg::BASE_W-1:0]   base_eff
);

  logic [rde_pkg::BASE_W-1:0]    base_r;
  logic [rde_pkg::BASE_W-1:0]    base_nxt;
  logic [rde_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rde_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == rde_pkg::REG_IDX_BASE);

  always_comb begin
    base_nxt = base_r;
    if (wr_en) begin
      base_nxt = pwdata[rde_pkg::BASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= rde_pkg::BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  // Out-of-range settings fold onto the nearest legal radix.
  always_comb begin
    if (base_r < rde_pkg::BASE_MIN) begin
      base_eff = rde_pkg::BASE_MIN;
    end else if (base_r > rde_pkg::BASE_MAX) begin
      base_eff = rde_pkg::BASE_MAX;
    end else begin
      base_eff = base_r;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rde_pkg::REG_IDX_BASE) begin
      prdata = rde_pkg::DATA_W'(base_r);
    end
  end

endmodule

/* src/rde_datapath.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter datapath
// Shared divider, digit stack memory and output register.
// ----------------------------------------------------------------------------
module rde_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rde_pkg::cmd_t               cmd,
  output rde_pkg::status_t            status,
  input  logic [rde_pkg::VALUE_W-1:0] value,
  input  logic [rde_pkg::BASE_W-1:0]  base_eff,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [rde_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last
);

  // Only the low bits of the value take part; at most one digit per bit.
  localparam int NB     = (VALUE_BITS < rde_pkg::VALUE_W) ? VALUE_BITS : rde_pkg::VALUE_W;
  localparam int W      = ((NB + rde_pkg::STEPS - 1) / rde_pkg::STEPS) * rde_pkg::STEPS;
  localparam int CHUNKS = W / rde_pkg::STEPS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IW     = $clog2(NB);
  localparam int DW     = $clog2(NB + 1);

  logic [W-1:0]                quot_r;
  logic [W-1:0]                quot_nxt;
  logic [rde_pkg::DIGIT_W-1:0] rem_r;
  logic [rde_pkg::DIGIT_W-1:0] rem_nxt;
  logic [CW-1:0]               chunk_r;
  logic [CW-1:0]               chunk_nxt;
  logic [DW-1:0]               depth_r;
  logic [DW-1:0]               depth_nxt;
  logic [rde_pkg::DIGIT_W-1:0] store [NB];
  logic [rde_pkg::DIGIT_W-1:0] rd_data_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [rde_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_last_r;

  logic [W-1:0]                q_div;
  logic [rde_pkg::DIGIT_W-1:0] r_div;
  logic                        push_en;
  logic [DW-1:0]               top_idx;

  // Eight restoring division steps; the remainder always stays below the base.
  always_comb begin
    logic [W-1:0]                 q;
    logic [rde_pkg::DIGIT_W:0]    r;
    q = quot_r;
    r = {1'b0, rem_r};
    for (int j = 0; j < rde_pkg::STEPS; j++) begin
      r = {r[rde_pkg::DIGIT_W-1:0], q[W-1]};
      q = {q[W-2:0], 1'b0};
      if (r >= base_eff) begin
        r    = r - base_eff;
        q[0] = 1'b1;
      end
    end
    q_div = q;
    r_div = r[rde_pkg::DIGIT_W-1:0];
  end

  assign push_en = cmd.div_step && (chunk_r == CW'(CHUNKS - 1));
  assign top_idx = depth_r - DW'(1);

  always_comb begin
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    depth_nxt = depth_r;
    if (cmd.load_value) begin
      quot_nxt  = W'(value[NB-1:0]);
      rem_nxt   = '0;
      chunk_nxt = '0;
      depth_nxt = '0;
    end else if (push_en) begin
      quot_nxt  = q_div;
      rem_nxt   = '0;
      chunk_nxt = '0;
      depth_nxt = depth_r + DW'(1);
    end else if (cmd.div_step) begin
      quot_nxt  = q_div;
      rem_nxt   = r_div;
      chunk_nxt = chunk_r + CW'(1);
    end else if (cmd.pop_read) begin
      depth_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
      depth_r <= '0;
    end else begin
      chunk_r <= chunk_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Digit stack: one write port at the fill level, one registered read port.
  always_ff @(posedge clk) begin
    if (push_en) begin
      store[depth_r[IW-1:0]] <= r_div;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_read) begin
      rd_data_r <= store[top_idx[IW-1:0]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= rde_pkg::glyph(rd_data_r);
      out_last_r <= (depth_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign status.chunk_last = (chunk_r == CW'(CHUNKS - 1));
  assign status.quot_zero  = (q_div == '0);
  assign status.depth_zero = (depth_r == '0);
  assign status.store_full = (depth_r == DW'(NB));
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

/* src/rde_ctrl.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter controller
// Sequences loading, repeated division and popping of the digit stack.
// ----------------------------------------------------------------------------
module rde_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rde_pkg::status_t status,
  output rde_pkg::cmd_t    cmd
);

  rde_pkg::state_t state_r;
  rde_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rde_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      rde_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_value = 1'b1;
          state_nxt      = rde_pkg::ST_DIV;
        end
      end
      rde_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.chunk_last && status.quot_zero) begin
          state_nxt = rde_pkg::ST_POP;
        end
      end
      rde_pkg::ST_POP: begin
        cmd.pop_read = 1'b1;
        state_nxt    = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.depth_zero) begin
            state_nxt = rde_pkg::ST_IDLE;
          end else begin
            cmd.pop_read = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = rde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/radix_digit_emitter_core.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter core
// Converts an unsigned value to ASCII digits in a configurable base, most
// significant digit first, one output word per digit.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake            Word contents
//   in_word    input      valid/ready          value
//   out_word   output     valid/ready          digit_char, last_digit
//   config     input      APB write/read       base (address 0)
//
// An item is loaded, then divided once per digit, each division working
// through CHUNKS chunks, where CHUNKS is the value width rounded up to a
// multiple of eight, divided by eight; then the stack is read and digits
// are emitted one per cycle while the output is not stalled.
// The shared divider retires eight quotient bits per cycle and sets the pace.
// Reset is synchronous and active low; it leaves the base at ten and the
// digit stack empty. A stalled output only holds the emit phase; the next
// input word is taken as soon as the last digit of a run sits in the
// output register.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_core_assert.svh"

module radix_digit_emitter_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rde_in_if.sink                       in_word,
  rde_out_if.source                    out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rde_pkg::PADDR_W-1:0]  paddr,
  input  logic [rde_pkg::DATA_W-1:0]   pwdata,
  output logic [rde_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  rde_pkg::cmd_t              cmd;
  rde_pkg::status_t           status;
  logic [rde_pkg::BASE_W-1:0] base_eff;
  logic                       in_ready;
  logic                       out_valid;
  logic [rde_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;

  // The base register; values outside two through sixteen are clamped here
  // so the divider only ever sees a legal radix.
  rde_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .base_eff (base_eff)
  );

  // The controller walks one word through load, divide, pop and emit.
  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath divides repeatedly, pushing each remainder onto the digit
  // stack, and then pops the stack into the output register so digits leave
  // most significant first. A zero value divides once and yields one '0'.
  rde_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .value     (in_word.value),
    .base_eff  (base_eff),
    .out_ready (out_word.ready),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  assign in_word.ready       = in_ready;
  assign out_word.valid      = out_valid;
  assign out_word.digit_char = out_char;
  assign out_word.last_digit = out_last;

  // Once a word is taken the block is busy until its last digit is loaded into the output register.
  `RDE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_word.valid && in_word.ready, !in_word.ready)
  // The stack is never popped when empty.
  `RDE_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, cmd.pop_read, !status.depth_zero)
  // A digit is loaded only when the output register is free or draining.
  `RDE_ASSERT_IMPLY(a_load_slot_free, clk, rst_n, cmd.out_load, status.out_free)
  // A remainder push always finds room on the stack.
  `RDE_ASSERT_IMPLY(a_push_has_room, clk, rst_n, cmd.div_step && status.chunk_last, !status.store_full)

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Radix digit emitter testbench
// Drives values into the emitter core under random idling on both channels,
// predicts the ASCII digit words for each accepted value in the current base,
// and checks every output word in order. The base register is reprogrammed
// over the APB port between phases, including out-of-range settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rde_pkg::*;

  // One expected output word: the ASCII digit and the end-of-run flag.
  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_word_t;

  // Register addresses. The base sits at index zero; the other index has no
  // register behind it, so writes there must leave the base alone.
  localparam logic [PADDR_W-1:0] BASE_ADDR  = {REG_IDX_BASE, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_IDX_BASE, 2'b00};

  // Long enough for a full base-two run, so this covers any item in flight.
  localparam int TAIL_CYCLES  = 170;
  // Long receiver hold-off used to back the core up into its input channel.
  localparam int CHOKE_CYCLES = 400;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  rde_in_if  in_ch ();
  rde_out_if out_ch ();

  radix_digit_emitter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Digit words still owed by the core, oldest first.
  digit_word_t       pending_digits[$];
  // Our own copy of the base register, exactly as written (five bits).
  logic [BASE_W-1:0] base_shadow;
  int                fail_count;
  // When set, neither side idles.
  bit                calm;
  // Asks the receiver process for one long hold-off.
  bit                choke_req;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the core hangs or drops words.
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ASCII code of one digit: '0'..'9', then 'A'..'F'.
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_W'(8'd48 + d);
    end
    return CHAR_W'(8'd55 + d);
  endfunction

  // Converts one value in the current base and queues its digit words, most
  // significant first. Base settings below two act as two and settings
  // above sixteen act as sixteen. Zero gives the single digit '0'.
  function automatic void predict_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] n;
    logic [VALUE_W-1:0] radix;
    logic [3:0]         remainders[$];
    digit_word_t        w;
    if (base_shadow < BASE_MIN) begin
      radix = VALUE_W'(BASE_MIN);
    end else if (base_shadow > BASE_MAX) begin
      radix = VALUE_W'(BASE_MAX);
    end else begin
      radix = VALUE_W'(base_shadow);
    end
    n = value;
    do begin
      remainders.push_back(4'(n % radix));
      n = n / radix;
    end while (n != '0);
    while (remainders.size() != 0) begin
      w.digit_char = digit_ascii(remainders.pop_back());
      w.last_digit = (remainders.size() == 0);
      pending_digits.push_back(w);
    end
  endfunction

  // Scoreboard. Both channels are sampled at the rising edge. A value's
  // digits can never leave in the cycle it is taken, so predicting before
  // checking within one edge keeps the queue in order.
  digit_word_t got_word;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_digits.size() == 0) begin
          $error("digit word with nothing pending: digit_char %0d last_digit %0b",
                 out_ch.digit_char, out_ch.last_digit);
          fail_count++;
        end else begin
          got_word = pending_digits.pop_front();
          if (out_ch.digit_char !== got_word.digit_char) begin
            $error("digit_char: expected %0d, actual %0d",
                   got_word.digit_char, out_ch.digit_char);
            fail_count++;
          end
          if (out_ch.last_digit !== got_word.last_digit) begin
            $error("last_digit: expected %0b, actual %0b",
                   got_word.last_digit, out_ch.last_digit);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver. Ready changes only at the falling edge. Short random stalls,
  // or one long hold-off when a test asks for it.
  int stall_left;
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (choke_req) begin
        choke_req  = 1'b0;
        stall_left = CHOKE_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one value and returns at the edge where it is accepted. Valid
  // stays high into the next call unless a random gap is taken first.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Ends a burst of values so that nothing is offered while we wait.
  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted word has come out, then lets the core settle.
  task automatic drain_digits(input int tail);
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle completing when pready is high.
  // The shadow only follows writes that land on the base register.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == BASE_ADDR) begin
      base_shadow = data[BASE_W-1:0];
    end
  endtask

  // Reads the base register back and compares it with the shadow.
  task automatic check_base_readback();
    logic [DATA_W-1:0] seen;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= BASE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== DATA_W'(base_shadow)) begin
      $error("base: expected %0d, actual %0d", base_shadow, seen);
      fail_count++;
    end
  endtask

  // Reprograms the base with random junk above the five register bits.
  task automatic set_base(input logic [BASE_W-1:0] base);
    logic [DATA_W-1:0] data;
    data             = $urandom();
    data[BASE_W-1:0] = base;
    apb_write(BASE_ADDR, data);
    check_base_readback();
  endtask

  // Mix of value shapes: full range, short numbers, powers of two and the values
  // just below them, and random values with some of their low sixteen bits cleared.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = VALUE_W'($urandom_range(0, 255));
      1:       v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      2:       v = (VALUE_W'(1) << $urandom_range(1, VALUE_W - 1)) - 1;
      3:       v = $urandom() & ~VALUE_W'($urandom_range(0, 65535));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Mostly legal radices, with the extremes and out-of-range settings mixed in.
  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0:       return BASE_W'($urandom_range(0, 31));
      1:       return BASE_MIN;
      2:       return BASE_MAX;
      default: return BASE_W'($urandom_range(2, 16));
    endcase
  endfunction

  // Base ten out of reset: zero, small values, the decade boundary and the
  // largest value.
  task automatic test_reset_base();
    check_base_readback();
    send_value('0);
    send_value(VALUE_W'(1));
    send_value(VALUE_W'(9));
    send_value(VALUE_W'(10));
    send_value('1);
    stop_sending();
    drain_digits(8);
  endtask

  // Base two gives the longest run (32 digits) and base sixteen the shortest.
  task automatic test_base_extremes();
    set_base(BASE_MIN);
    send_value('1);
    send_value(VALUE_W'(32'h8000_0000));
    send_value('0);
    send_value(VALUE_W'(1));
    stop_sending();
    drain_digits(8);
    set_base(BASE_MAX);
    send_value('1);
    send_value('0);
    send_value(VALUE_W'(15));
    send_value(VALUE_W'(16));
    stop_sending();
    drain_digits(8);
  endtask

  // Settings below two must act as two, settings above sixteen as sixteen.
  task automatic test_base_clamp();
    set_base(BASE_W'(0));
    send_value(VALUE_W'(5));
    stop_sending();
    drain_digits(8);
    set_base(BASE_W'(1));
    send_value('1);
    stop_sending();
    drain_digits(8);
    set_base(BASE_W'(17));
    send_value(VALUE_W'(32'hABCD_EF12));
    stop_sending();
    drain_digits(8);
    set_base(BASE_W'(31));
    send_value(VALUE_W'(255));
    stop_sending();
    drain_digits(8);
  endtask

  // A write to an index with no register behind it is ignored.
  task automatic test_unknown_register();
    set_base(BASE_W'(7));
    apb_write(SPARE_ADDR, DATA_W'(3));
    check_base_readback();
    send_value(VALUE_W'(12345));
    stop_sending();
    drain_digits(8);
  endtask

  // The receiver holds off for a long stretch while values keep coming, so
  // the core fills its output register, stops dividing and stalls its input.
  task automatic test_backpressure();
    set_base(pick_base());
    choke_req = 1'b1;
    repeat (16) send_value(pick_value());
    stop_sending();
    drain_digits(8);
  endtask

  // Random phases, each with a fresh base. One phase runs without idling.
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      set_base(pick_base());
      calm = (phase == 2);
      repeat (45) send_value(pick_value());
      stop_sending();
      drain_digits(8);
    end
    calm = 1'b0;
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_quiet_tail();
    calm = 1'b1;
    set_base(pick_base());
    repeat (25) send_value(pick_value());
    stop_sending();
  endtask

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    base_shadow  = BASE_RESET;
    fail_count   = 0;
    calm         = 1'b0;
    choke_req    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_base();
    test_base_extremes();
    test_base_clamp();
    test_unknown_register();
    test_backpressure();
    test_random_phases();
    test_quiet_tail();
    drain_digits(TAIL_CYCLES);

    if (pending_digits.size() != 0) begin
      $error("digit words never delivered: %0d", pending_digits.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
